@@ rtl/core/message_frame_deframer_core_defines.svh @@
// Assertion macros for the message frame deframer core.
// Depends on nothing; included by the files that carry assertions.
`ifndef MESSAGE_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define MESSAGE_FRAME_DEFRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising clock edge outside of reset.
`define MFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define MFD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MFD_ASSERT(label, prop, msg)
`define MFD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/core/mfd_pkg.sv @@
// Types and constants shared by the message frame deframer core.
// Depends on nothing; imported by mfd_parser and the top level.
`default_nettype none

package mfd_pkg;

   // Parser phases. Codes beyond the last member behave like the flags phase.
   typedef enum logic [2:0] {
      PH_FLAGS = 3'd0,
      PH_SHORT = 3'd1,
      PH_LONG  = 3'd2,
      PH_BODY  = 3'd3,
      PH_SKIP  = 3'd4
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_BODY     = 2'd0;
   localparam logic [1:0] KIND_EMPTY    = 2'd1;
   localparam logic [1:0] KIND_OVERSIZE = 2'd2;

   // Flags byte bit positions.
   localparam int FLAG_MORE_BIT    = 0;
   localparam int FLAG_LARGE_BIT   = 1;
   localparam int FLAG_COMMAND_BIT = 2;

   // A large size field is eight bytes, big-endian.
   localparam int          LONG_SIZE_BYTES = 8;
   localparam logic [2:0]  SIZE_INDEX_LAST = 3'(LONG_SIZE_BYTES - 1);

   localparam logic [31:0] MAX_FRAME_SIZE_RESET = 32'd65535;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  body_byte;
      logic        last_of_frame;
      logic        more_flag;
      logic        command_flag;
      logic [31:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/message_frame_deframer_core.sv @@
// Top level of the message frame deframer: input register, parser, result register.
// Depends on mfd_pkg, mfd_parser and message_frame_deframer_core_defines.svh.
//
//   Channel | Ports                            | Direction | Moves
//   --------+----------------------------------+-----------+-------------------------
//   req     | req_valid, req_stall, req_*      | in        | one stream byte
//   rsp     | rsp_valid, rsp_stall, rsp_*      | out       | one result (body/empty/error)
//   csr     | csr_write_enable, csr_write_data | in        | max_frame_size register
//
// One byte is taken per cycle unless rsp stalls; a byte moves from the input register
// to the result register through the single parser step, which sets the rate.
// Reset is synchronous and active high; it returns the parser to the flags phase and
// sets max_frame_size to 65535. A stall on rsp holds the result register, and the
// input register then fills and stalls req in turn.
`default_nettype none

`include "message_frame_deframer_core_defines.svh"

module message_frame_deframer_core
   import mfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_body_byte,
   output logic             rsp_last_of_frame,
   output logic             rsp_more_flag,
   output logic             rsp_command_flag,
   output logic [31:0]      rsp_frame_length,

   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   logic [31:0] max_frame_size_ff;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        req_accept;
   logic        advance;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;

   logic        parse_valid;
   result_type  parse_result;

   // The user must write the configuration register only while the block is idle; the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_size_ff <= MAX_FRAME_SIZE_RESET;
      end else if (csr_write_enable) begin
         max_frame_size_ff <= csr_write_data;
      end
   end

   // The byte in the input register moves through the parser whenever the result
   // register is empty or its contents leave in this same cycle. A byte that gives
   // no result still moves, so skipped bodies drain at full rate.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   mfd_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .stream_byte    (in_byte_ff),
      .max_frame_size (max_frame_size_ff),
      .result_valid   (parse_valid),
      .result         (parse_result)
   );

   // The result register holds until its transfer completes.
   always_comb begin
      if (advance) begin
         out_valid_in = parse_valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && parse_valid) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_ff.result_kind;
   assign rsp_body_byte     = out_ff.body_byte;
   assign rsp_last_of_frame = out_ff.last_of_frame;
   assign rsp_more_flag     = out_ff.more_flag;
   assign rsp_command_flag  = out_ff.command_flag;
   assign rsp_frame_length  = out_ff.frame_length;

   // Empty and oversize results always close their frame and carry no body byte.
   `MFD_ASSERT(a_single_result_closes, rsp_valid && (rsp_result_kind == KIND_EMPTY || rsp_result_kind == KIND_OVERSIZE) |-> rsp_last_of_frame && rsp_body_byte == 8'd0, "empty or oversize result without last mark")
   // An empty frame reports a length of zero.
   `MFD_ASSERT(a_empty_length, rsp_valid && rsp_result_kind == KIND_EMPTY |-> rsp_frame_length == 32'd0, "empty frame with nonzero length")
   // The input side stalls only while a byte waits in the input register and rsp stalls a held result.
   `MFD_ASSERT(a_stall_needs_byte, req_stall |-> in_valid_ff && out_valid_ff && rsp_stall, "input stalled without cause")
   // Reset leaves both registers empty.
   `MFD_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid && !req_stall, "registers not empty after reset")

endmodule

`default_nettype wire

@@ rtl/core/mfd_parser.sv @@
// Frame parser: phase, size and body counters, and the result of one byte.
// Depends on mfd_pkg.
`default_nettype none

module mfd_parser
   import mfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  stream_byte,
   input  wire logic [31:0] max_frame_size,
   output logic             result_valid,
   output result_type       result
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  size_index_ff, size_index_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] length_ff, length_in;
   logic [1:0]  flags_ff, flags_in;

   logic [63:0] size_value;
   logic        size_last;
   logic        size_over;
   logic [31:0] size_sat;
   logic [63:0] remaining_dec;
   logic        remaining_one;
   logic [1:0]  kind;
   logic [7:0]  body;
   logic        last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FLAGS;
         size_index_ff <= '0;
         remaining_ff  <= '0;
         length_ff     <= '0;
         flags_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         size_index_ff <= size_index_in;
         remaining_ff  <= remaining_in;
         length_ff     <= length_in;
         flags_ff      <= flags_in;
      end
   end

   // The size so far with the new byte shifted in at the bottom.
   assign size_value    = (phase_ff == PH_SHORT) ? {56'd0, stream_byte}
                                                 : {remaining_ff[55:0], stream_byte};
   assign size_last     = (phase_ff == PH_SHORT) ||
                          (phase_ff == PH_LONG && size_index_ff == SIZE_INDEX_LAST);
   assign size_over     = (|size_value[63:32]) || (size_value[31:0] > max_frame_size);
   assign size_sat      = (|size_value[63:32]) ? '1 : size_value[31:0];
   assign remaining_dec = remaining_ff - 64'd1;
   assign remaining_one = (remaining_ff == 64'd1);

   always_comb begin
      phase_in      = phase_ff;
      size_index_in = size_index_ff;
      remaining_in  = remaining_ff;
      length_in     = length_ff;
      flags_in      = flags_ff;
      result_valid  = 1'b0;
      kind          = KIND_BODY;
      body          = '0;
      last          = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_SHORT, PH_LONG: begin
               remaining_in = size_value;
               if (phase_ff == PH_LONG) begin
                  size_index_in = size_index_ff + 3'd1;
               end
               if (size_last) begin
                  length_in = size_sat;
                  if (size_value == 64'd0) begin
                     phase_in     = PH_FLAGS;
                     result_valid = 1'b1;
                     kind         = KIND_EMPTY;
                     last         = 1'b1;
                  end else if (size_over) begin
                     phase_in     = PH_SKIP;
                     result_valid = 1'b1;
                     kind         = KIND_OVERSIZE;
                     last         = 1'b1;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               result_valid = 1'b1;
               kind         = KIND_BODY;
               body         = stream_byte;
               last         = remaining_one;
               remaining_in = remaining_dec;
               if (remaining_one) begin
                  phase_in = PH_FLAGS;
               end
            end
            PH_SKIP: begin
               remaining_in = remaining_dec;
               if (remaining_one) begin
                  phase_in = PH_FLAGS;
               end
            end
            default: begin
               flags_in      = {stream_byte[FLAG_COMMAND_BIT], stream_byte[FLAG_MORE_BIT]};
               size_index_in = '0;
               remaining_in  = '0;
               phase_in      = stream_byte[FLAG_LARGE_BIT] ? PH_LONG : PH_SHORT;
            end
         endcase
      end
   end

   always_comb begin
      result.result_kind   = kind;
      result.body_byte     = body;
      result.last_of_frame = last;
      result.more_flag     = flags_ff[0];
      result.command_flag  = flags_ff[1];
      result.frame_length  = length_in;
   end

endmodule

`default_nettype wire

@@ dv/message_frame_deframer_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for message_frame_deframer_core: frames go in as bytes, results
// are checked against an in-bench model of the parser. Depends on mfd_pkg and the RTL.

module message_frame_deframer_core_tb
   import mfd_pkg::*;
();

   // Clock, reset and every port that the bench drives start at known values.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_body_byte;
   logic        rsp_last_of_frame;
   logic        rsp_more_flag;
   logic        rsp_command_flag;
   logic [31:0] rsp_frame_length;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = 32'h0;

   // Deframer model state. It mirrors the parser one byte at a time.
   phase_type   frame_phase = PH_FLAGS;
   logic [2:0]  size_index = 3'd0;
   logic [63:0] bytes_left = 64'd0;
   logic [31:0] frame_len = 32'd0;
   logic        frame_more = 1'b0;
   logic        frame_cmd = 1'b0;
   logic [31:0] max_size = MAX_FRAME_SIZE_RESET;

   // Results that the model has produced and the block has not yet delivered, oldest first.
   result_type  expected_results[$];

   // Traffic shaping. The percentages give the chance of an idle cycle on each side, and
   // rsp_hold_left forces a long unbroken stall on the result channel.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;

   int error_count = 0;
   int bytes_sent = 0;
   int results_checked = 0;
   int body_results = 0;
   int empty_results = 0;
   int oversize_results = 0;
   int input_stall_cycles = 0;

   message_frame_deframer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_body_byte     (rsp_body_byte),
      .rsp_last_of_frame (rsp_last_of_frame),
      .rsp_more_flag     (rsp_more_flag),
      .rsp_command_flag  (rsp_command_flag),
      .rsp_frame_length  (rsp_frame_length),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // Period of 4 ns: two ns high, two ns low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is cut off here if anything hangs. A correct run needs only a small
   // fraction of this, even with both sides idling most of the time.
   initial begin
      #(4_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Prints the first few mismatches and counts all of them.
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 30) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last);
      result_type r;
      r.result_kind   = kind;
      r.body_byte     = data;
      r.last_of_frame = last;
      r.more_flag     = frame_more;
      r.command_flag  = frame_cmd;
      r.frame_length  = frame_len;
      expected_results.push_back(r);
   endfunction

   // Called when the final size byte is in. The limit check and the skip count use the
   // full 64-bit length; only the reported length saturates.
   function automatic void finish_size(input logic [63:0] len);
      frame_len  = (len > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
      bytes_left = len;
      if (len == 64'd0) begin
         frame_phase = PH_FLAGS;
         push_result(KIND_EMPTY, 8'h00, 1'b1);
      end else if (len > {32'd0, max_size}) begin
         frame_phase = PH_SKIP;
         push_result(KIND_OVERSIZE, 8'h00, 1'b1);
      end else begin
         frame_phase = PH_BODY;
      end
   endfunction

   // Advances the model by one accepted stream byte.
   function automatic void predict_deframe(input logic [7:0] b);
      case (frame_phase)
         PH_SHORT: begin
            finish_size({56'd0, b});
         end
         PH_LONG: begin
            bytes_left = {bytes_left[55:0], b};
            if (size_index == SIZE_INDEX_LAST) begin
               size_index = 3'd0;
               finish_size(bytes_left);
            end else begin
               size_index = size_index + 3'd1;
            end
         end
         PH_BODY: begin
            push_result(KIND_BODY, b, bytes_left == 64'd1);
            bytes_left = bytes_left - 64'd1;
            if (bytes_left == 64'd0) begin
               frame_phase = PH_FLAGS;
            end
         end
         PH_SKIP: begin
            bytes_left = bytes_left - 64'd1;
            if (bytes_left == 64'd0) begin
               frame_phase = PH_FLAGS;
            end
         end
         default: begin
            // Only the more, large and command bits matter; the reserved bits are ignored.
            frame_more  = b[FLAG_MORE_BIT];
            frame_cmd   = b[FLAG_COMMAND_BIT];
            size_index  = 3'd0;
            bytes_left  = 64'd0;
            frame_phase = b[FLAG_LARGE_BIT] ? PH_LONG : PH_SHORT;
         end
      endcase
   endfunction

   // Offers one byte and returns at the falling edge after its transfer. Valid stays high
   // between back-to-back bytes, so it is never lowered and raised in the same step.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      predict_deframe(b);
      @(negedge clock);
   endtask

   // Sends a flags byte, a one-byte or eight-byte size, and optionally a random body.
   task automatic send_frame(input logic [7:0] flags, input bit long_form,
                             input logic [63:0] len, input bit with_body);
      logic [63:0] n;
      flags[FLAG_LARGE_BIT] = long_form;
      send_byte(flags);
      if (long_form) begin
         for (int i = LONG_SIZE_BYTES - 1; i >= 0; i--) begin
            send_byte(len[8*i +: 8]);
         end
      end else begin
         send_byte(len[7:0]);
      end
      if (with_body) begin
         for (n = 64'd0; n < len; n++) begin
            send_byte(8'($urandom));
         end
      end
   endtask

   // Mostly well-formed frames around the current limit. About one frame in ten is short
   // form with a fully random size byte, which is as close to noise as the stream allows
   // without locking the parser into a multi-gigabyte skip.
   task automatic send_random_frame();
      logic [7:0]  flags;
      bit          long_form;
      logic [63:0] len;
      int          pick;
      flags     = 8'($urandom);
      long_form = ($urandom_range(3) == 0);
      pick      = $urandom_range(99);
      if (pick < 10) begin
         len = 64'd0;
      end else if (pick < 20) begin
         len       = 64'($urandom_range(255));
         long_form = 1'b0;
      end else if (pick < 32 && max_size <= 32'd300) begin
         len = {32'd0, max_size};
      end else if (pick < 44 && max_size < 32'd300) begin
         len = {32'd0, max_size} + 64'd1;
      end else if (pick < 95) begin
         len = 64'($urandom_range(16, 1));
      end else begin
         len = 64'($urandom_range(300, 17));
      end
      if (len > 64'd255) begin
         long_form = 1'b1;
      end
      send_frame(flags, long_form, len, 1'b1);
   endtask

   task automatic set_idle_mode(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // The limit is only changed with the block idle: every result delivered, then a further
   // wait so that bytes that give no result have left the pipeline too.
   task automatic write_max_size(input logic [31:0] value);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      max_size = value;
   endtask

   // Short frames at the reset limit: a one-byte body, an empty command frame whose
   // reserved flag bits are all set, and a long-form size that holds a small length.
   task automatic test_directed_frames();
      set_idle_mode(0, 0);
      send_byte(8'h01);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(8'hFC);
      send_byte(8'h00);
      send_frame(8'h04, 1'b1, 64'd2, 1'b0);
      send_byte(8'hFF);
      send_byte(8'h5A);
   endtask

   // The limit boundary: one byte over is reported and its body swallowed, exactly at the
   // limit passes. With a limit of zero only empty frames get through.
   task automatic test_frame_limits();
      write_max_size(32'd2);
      send_frame(8'h00, 1'b0, 64'd3, 1'b1);
      send_frame(8'h01, 1'b0, 64'd2, 1'b1);
      write_max_size(32'd0);
      send_frame(8'h00, 1'b0, 64'd0, 1'b0);
      send_frame(8'h04, 1'b0, 64'd1, 1'b1);
   endtask

   // Eight phases of random frames, each with its own limit and one of four traffic patterns.
   task automatic test_random_traffic();
      logic [31:0] limits [0:7] = '{32'd0, 32'd1, 32'd16, 32'd255, 32'd256,
                                    MAX_FRAME_SIZE_RESET, 32'hFFFF_FFFF, 32'd8};
      int          start;
      limits[7] = 32'($urandom_range(300, 2));
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0:       set_idle_mode(0, 0);
            1:       set_idle_mode(87, 0);
            2:       set_idle_mode(0, 87);
            default: set_idle_mode(20, 20);
         endcase
         write_max_size(limits[p]);
         start = bytes_sent;
         while (bytes_sent - start < 80) begin
            send_random_frame();
         end
      end
   endtask

   // The result side holds off for a long stretch while bytes keep coming, so the block
   // fills up and has to stall its input.
   task automatic test_backpressure();
      set_idle_mode(0, 0);
      write_max_size(32'hFFFF_FFFF);
      @(posedge clock);
      rsp_hold_left = 300;
      @(negedge clock);
      send_frame(8'h01, 1'b1, 64'd120, 1'b1);
      for (int i = 0; i < 6; i++) begin
         send_random_frame();
      end
   endtask

   // A length just above 32 bits must be reported as oversize even at the widest limit,
   // with a saturated length, and the skip count must not wrap at 32 bits: everything
   // sent afterwards is swallowed. The parser never leaves the skip, so this runs last.
   task automatic test_huge_length();
      set_idle_mode(20, 20);
      write_max_size(32'hFFFF_FFFF);
      send_frame(8'h03, 1'b1, 64'h0000_0001_0000_0003, 1'b0);
      for (int i = 0; i < 8; i++) begin
         send_random_frame();
      end
   endtask

   // The receiver side: a forced hold when one is pending, otherwise random stalls.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Checks each result transfer against the oldest outstanding expectation.
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && req_valid && req_stall) begin
         input_stall_cycles++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_result_kind, rsp_body_byte, rsp_last_of_frame, rsp_more_flag,
                 rsp_command_flag, rsp_frame_length};
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with none outstanding, kind %0d",
                                      seen.result_kind));
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            case (want.result_kind)
               KIND_BODY:  body_results++;
               KIND_EMPTY: empty_results++;
               default:    oversize_results++;
            endcase
            if (seen.result_kind !== want.result_kind)
               report_mismatch($sformatf("result_kind %0d, expected %0d",
                                         seen.result_kind, want.result_kind));
            if (seen.body_byte !== want.body_byte)
               report_mismatch($sformatf("body_byte %02h, expected %02h",
                                         seen.body_byte, want.body_byte));
            if (seen.last_of_frame !== want.last_of_frame)
               report_mismatch($sformatf("last_of_frame %b, expected %b",
                                         seen.last_of_frame, want.last_of_frame));
            if (seen.more_flag !== want.more_flag)
               report_mismatch($sformatf("more_flag %b, expected %b",
                                         seen.more_flag, want.more_flag));
            if (seen.command_flag !== want.command_flag)
               report_mismatch($sformatf("command_flag %b, expected %b",
                                         seen.command_flag, want.command_flag));
            if (seen.frame_length !== want.frame_length)
               report_mismatch($sformatf("frame_length %0d, expected %0d",
                                         seen.frame_length, want.frame_length));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_frame_limits();
      test_random_traffic();
      test_backpressure();
      test_huge_length();

      // Drain: stop offering bytes, let the results out, then allow for the pipeline.
      req_valid <= 1'b0;
      set_idle_mode(0, 0);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d stream bytes; checked %0d results (%0d body, %0d empty, %0d oversize).",
               bytes_sent, results_checked, body_results, empty_results, oversize_results);
      $display("Input was held off for %0d cycles under result back-pressure.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
